FILE: sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Request and response structs, operation kinds and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Operation kinds carried in the request
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_KEY     = 2'd1;  // key present on insert, absent on remove
  localparam logic [1:0] ST_BOUNDS  = 2'd2;  // table full on insert, empty on remove

  typedef struct packed {
    logic               kind;
    logic signed [31:0] entry_key;
    logic        [31:0] entry_payload;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       is_full;
  } out_rsp_t;

  // One stored table slot
  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] payload;
  } entry_t;

endpackage

FILE: sv/skt_spram.sv
// ----------------------------------------------------------------------------
// skt_spram: single-port table memory
// One access per cycle, read or write; read data is registered.
// ----------------------------------------------------------------------------
module skt_spram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            we_i,
  input  logic [AW-1:0]   addr_i,
  input  skt_pkg::entry_t wdata_i,
  output skt_pkg::entry_t rdata_o
);

  skt_pkg::entry_t mem [DEPTH];
  skt_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: bounded table of entries kept in ascending key order
// Inserts and removes signed keys with payload handles in a one-port memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_req_i) is taken when in_valid_i and in_ready_o are high.
//   Insert places the entry in key order; it is refused when the table is
//   full or the key is already held. Remove deletes the matching key; it
//   reports an empty table or an absent key. Each request yields exactly one
//   response (out_rsp_o) with status, new count and empty/full flags, taken
//   when out_valid_o and out_ready_i are high.
//   Operation: a linear search reads one slot at a time, then entries move
//   one slot at a time through the single memory port; each slot searched
//   takes a read state and a compare state, and each entry moved takes a
//   read state and a write state. A full or empty table is refused without
//   a search. in_ready_o returns high in the same cycle the response appears.
//   in_ready_o is low while a request is worked on. The response sits in an
//   output register, so a new request is accepted while it waits; a second
//   finished response waits inside until the receiver takes the first.
//   Reset empties the table at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  skt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output skt_pkg::out_rsp_t out_rsp_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SRCH_RD = 7'b0000010,
    S_SRCH_CM = 7'b0000100,
    S_MOVE_RD = 7'b0001000,
    S_MOVE_WR = 7'b0010000,
    S_PUT     = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic               kind_q, kind_d;
  logic signed [31:0] key_q, key_d;
  logic        [31:0] pay_q, pay_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [1:0]         status_q, status_d;

  logic               out_valid_q, out_valid_d;
  skt_pkg::out_rsp_t  out_rsp_q, out_rsp_d;

  // memory port
  logic            mem_en, mem_we;
  logic [CW-1:0]   mem_idx;
  skt_pkg::entry_t mem_wdata, mem_rdata;

  logic [CW:0]     ptr_inc;
  logic [CW-1:0]   ptr_dec;
  logic [CW+4:0]   count_ext;
  logic            load_out;

  assign ptr_inc   = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
  assign ptr_dec   = ptr_q - CW'(1);
  assign count_ext = {5'b0, count_d};

  skt_spram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_idx[AW-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    key_d      = key_q;
    pay_d      = pay_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    pos_d      = pos_q;
    status_d   = status_q;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_idx    = ptr_q;
    mem_wdata  = mem_rdata;
    load_out   = 1'b0;
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_req_i.kind;
          key_d    = in_req_i.entry_key;
          pay_d    = in_req_i.entry_payload;
          ptr_d    = '0;
          status_d = skt_pkg::ST_DONE;
          if (in_req_i.kind == skt_pkg::KIND_INSERT && count_q == CW'(CAPACITY)) begin
            status_d = skt_pkg::ST_BOUNDS;
            state_d  = S_FINISH;
          end else if (in_req_i.kind == skt_pkg::KIND_REMOVE && count_q == '0) begin
            status_d = skt_pkg::ST_BOUNDS;
            state_d  = S_FINISH;
          end else begin
            state_d  = S_SRCH_RD;
          end
        end
      end

      // read the next slot, or stop at the end of the held entries
      S_SRCH_RD: begin
        if (ptr_q == count_q) begin
          pos_d = ptr_q;
          if (kind_q == skt_pkg::KIND_INSERT) begin
            ptr_d   = count_q;
            state_d = S_MOVE_RD;
          end else begin
            status_d = skt_pkg::ST_KEY;
            state_d  = S_FINISH;
          end
        end else begin
          mem_en  = 1'b1;
          state_d = S_SRCH_CM;
        end
      end

      // compare the slot key against the request key
      S_SRCH_CM: begin
        if (mem_rdata.key < key_q) begin
          ptr_d   = ptr_inc[CW-1:0];
          state_d = S_SRCH_RD;
        end else begin
          pos_d = ptr_q;
          if (mem_rdata.key == key_q) begin
            if (kind_q == skt_pkg::KIND_INSERT) begin
              status_d = skt_pkg::ST_KEY;
              state_d  = S_FINISH;
            end else begin
              state_d = S_MOVE_RD;
            end
          end else begin
            if (kind_q == skt_pkg::KIND_INSERT) begin
              ptr_d   = count_q;
              state_d = S_MOVE_RD;
            end else begin
              status_d = skt_pkg::ST_KEY;
              state_d  = S_FINISH;
            end
          end
        end
      end

      // read the neighbor that moves into slot ptr
      S_MOVE_RD: begin
        if (kind_q == skt_pkg::KIND_INSERT) begin
          if (ptr_q == pos_q) begin
            state_d = S_PUT;
          end else begin
            mem_en  = 1'b1;
            mem_idx = ptr_dec;
            state_d = S_MOVE_WR;
          end
        end else begin
          if (ptr_inc >= {1'b0, count_q}) begin
            count_d = count_q - CW'(1);
            state_d = S_FINISH;
          end else begin
            mem_en  = 1'b1;
            mem_idx = ptr_inc[CW-1:0];
            state_d = S_MOVE_WR;
          end
        end
      end

      // write the moved entry and step toward the gap
      S_MOVE_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (kind_q == skt_pkg::KIND_INSERT) begin
          ptr_d = ptr_dec;
        end else begin
          ptr_d = ptr_inc[CW-1:0];
        end
        state_d = S_MOVE_RD;
      end

      // place the new entry in the opened slot
      S_PUT: begin
        mem_en            = 1'b1;
        mem_we            = 1'b1;
        mem_idx           = pos_q;
        mem_wdata.key     = key_q;
        mem_wdata.payload = pay_q;
        count_d           = count_q + CW'(1);
        state_d           = S_FINISH;
      end

      // hand the response to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d           = 1'b1;
      out_rsp_d.status      = status_q;
      out_rsp_d.entry_count = count_ext[4:0];
      out_rsp_d.is_empty    = (count_q == '0);
      out_rsp_d.is_full     = (count_q == CW'(CAPACITY));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

FILE: verif/sorted_key_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_test: self-checking bench for the sorted key table
// A clocked driver feeds insert and remove requests from a pending queue and
// predicts each response with its own copy of the ordered table. A clocked
// monitor compares every response field by field. Both sides stall at
// random. One long receiver hold-off fills the block, and the sender waits
// for the block to drain at a few points.
// ----------------------------------------------------------------------------
module sorted_key_table_test;

  localparam int TBL_CAP        = 16;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int KEY_POOL_SIZE  = 24;
  localparam int HOLD_AFTER     = 300;   // responses seen before the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_EVERY    = 250;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUIET_FROM     = 20000;
  localparam int QUIET_TO       = 26000;

  typedef struct {
    skt_pkg::in_req_t req;
    bit               wait_drain;   // hold this request until every response is back
  } pending_req_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready_o;
  skt_pkg::in_req_t  in_req;
  logic              out_valid_o;
  logic              out_ready;
  skt_pkg::out_rsp_t out_rsp_o;

  pending_req_t      pending_reqs[$];
  skt_pkg::out_rsp_t expected_rsp[$];

  // Predictor copy of the table
  logic signed [31:0] tbl_key[TBL_CAP];
  logic        [31:0] tbl_pay[TBL_CAP];
  int                 tbl_count;

  int  n_sent;
  int  n_got;
  int  n_total;
  int  errors;
  int  cyc;
  int  idle_run;
  int  hold_left;
  bit  held_once;
  bit  quiet;
  logic drv_took;

  logic signed [31:0] key_pool[KEY_POOL_SIZE];

  sorted_key_table #(
    .CAPACITY (TBL_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  // Apply one request to the table copy and return the response it gives
  function automatic skt_pkg::out_rsp_t apply_table_op(input skt_pkg::in_req_t r);
    skt_pkg::out_rsp_t rsp;
    int                pos;
    int                i;
    rsp.status = skt_pkg::ST_DONE;
    pos = 0;
    while (pos < tbl_count && tbl_key[pos] < r.entry_key) pos++;
    if (r.kind == skt_pkg::KIND_INSERT) begin
      if (tbl_count >= TBL_CAP) begin
        rsp.status = skt_pkg::ST_BOUNDS;
      end else if (pos < tbl_count && tbl_key[pos] == r.entry_key) begin
        rsp.status = skt_pkg::ST_KEY;
      end else begin
        for (i = tbl_count; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_pay[i] = tbl_pay[i-1];
        end
        tbl_key[pos] = r.entry_key;
        tbl_pay[pos] = r.entry_payload;
        tbl_count++;
      end
    end else begin
      if (tbl_count == 0) begin
        rsp.status = skt_pkg::ST_BOUNDS;
      end else if (pos >= tbl_count || tbl_key[pos] != r.entry_key) begin
        rsp.status = skt_pkg::ST_KEY;
      end else begin
        for (i = pos; i + 1 < tbl_count; i++) begin
          tbl_key[i] = tbl_key[i+1];
          tbl_pay[i] = tbl_pay[i+1];
        end
        tbl_count--;
      end
    end
    rsp.entry_count = tbl_count[4:0];
    rsp.is_empty    = (tbl_count == 0);
    rsp.is_full     = (tbl_count >= TBL_CAP);
    return rsp;
  endfunction

  task automatic queue_req(input logic kind, input logic signed [31:0] key,
                           input logic [31:0] payload, input bit wait_drain);
    pending_req_t p;
    p.req.kind          = kind;
    p.req.entry_key     = key;
    p.req.entry_payload = payload;
    p.wait_drain        = wait_drain;
    pending_reqs.push_back(p);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Request driver: predicts on acceptance, then offers the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      n_sent   <= 0;
    end else begin
      drv_took = in_valid && in_ready_o;
      if (drv_took) begin
        expected_rsp.push_back(apply_table_op(in_req));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || drv_took) begin
        if (pending_reqs.size() == 0 ||
            (!quiet && $urandom_range(0, 99) < 14) ||
            (pending_reqs[0].wait_drain && (drv_took || n_sent != n_got))) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req   <= pending_reqs[0].req;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Response monitor with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    skt_pkg::out_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      n_got     <= 0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_got <= n_got + 1;
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            errors++;
          end
          if (out_rsp_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_rsp_o.entry_count);
            errors++;
          end
          if (out_rsp_o.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_rsp_o.is_empty);
            errors++;
          end
          if (out_rsp_o.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, out_rsp_o.is_full);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && n_got >= HOLD_AFTER) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Cycle count, quiet window and watchdog on handshake activity
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc      <= 0;
      idle_run <= 0;
      quiet    <= 1'b0;
    end else begin
      cyc   <= cyc + 1;
      quiet <= (cyc >= QUIET_FROM && cyc < QUIET_TO);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int          i;
    int          ins_pct;
    logic        kind;
    logic signed [31:0] key;
    errors    = 0;
    tbl_count = 0;
    rst_ni    = 1'b0;

    // Directed: empty remove, key extremes, duplicate, fill, full refusals
    queue_req(skt_pkg::KIND_REMOVE, 32'sd0, 32'h0, 1'b0);
    queue_req(skt_pkg::KIND_INSERT, 32'sh8000_0000, 32'h0000_0000, 1'b0);
    queue_req(skt_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(skt_pkg::KIND_INSERT, 32'sd0, 32'h1234_5678, 1'b0);
    queue_req(skt_pkg::KIND_INSERT, 32'sd0, 32'hDEAD_BEEF, 1'b0);  // duplicate keeps payload
    queue_req(skt_pkg::KIND_INSERT, -32'sd1, 32'hA5A5_A5A5, 1'b0);
    for (i = 0; i < 12; i++) begin
      queue_req(skt_pkg::KIND_INSERT,
                (i % 2 == 0) ? 32'sd100 * (i + 1) : -32'sd100 * (i + 1),
                $urandom, 1'b0);
    end
    queue_req(skt_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 32'h5A5A_5A5A, 1'b0);  // full, key present
    queue_req(skt_pkg::KIND_INSERT, 32'sd12345, 32'h0F0F_0F0F, 1'b0);      // full, new key
    queue_req(skt_pkg::KIND_REMOVE, 32'sd55, 32'hFFFF_FFFF, 1'b0);         // absent key
    queue_req(skt_pkg::KIND_REMOVE, 32'sh8000_0000, $urandom, 1'b0);
    queue_req(skt_pkg::KIND_REMOVE, 32'sh7FFF_FFFF, $urandom, 1'b0);
    queue_req(skt_pkg::KIND_REMOVE, 32'sd0, $urandom, 1'b0);

    // Small key pool so inserts collide and removes hit
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // Random: insert bias changes every few dozen requests to sweep the count
    ins_pct = 50;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 20;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      kind = ($urandom_range(0, 99) < ins_pct) ? skt_pkg::KIND_INSERT : skt_pkg::KIND_REMOVE;
      key  = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                          : $urandom;
      queue_req(kind, key, $urandom, (i % DRAIN_EVERY == 0));
    end
    n_total = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_got < n_total) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_rsp.size() != 0) begin
        $error("%0d responses never arrived", expected_rsp.size());
      end
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/skt_pkg.sv
sv/skt_spram.sv
sv/sorted_key_table.sv
verif/sorted_key_table_test.sv
